FILE: sv/cdg_pkg.sv
// ----------------------------------------------------------------------------
// cdg_pkg: click / drag gesture recognizer shared definitions
// Request and result layouts, command and gesture codes, register indexes,
// configuration and state bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package cdg_pkg;

	// coordinate and register widths
	localparam int CoordBits  = 12;
	localparam int ThreshBits = 25;
	localparam int TicksBits  = 16;
	localparam int DistBits   = (2 * CoordBits + 1 > ThreshBits) ?
		2 * CoordBits + 1 : ThreshBits;
	localparam int CfgDataBits = ThreshBits;
	localparam int CfgIdxBits  = 1;

	// register reset values
	localparam logic [ThreshBits-1:0] THRESH_RESET = ThreshBits'(25);
	localparam logic [TicksBits-1:0]  TICKS_RESET  = TicksBits'(1000);

	// register indexes
	localparam logic [CfgIdxBits-1:0] REG_DRAG_THRESHOLD_SQ = 1'b0;
	localparam logic [CfgIdxBits-1:0] REG_AUTO_DRAG_TICKS   = 1'b1;

	// request commands
	localparam logic [2:0] CMD_BUTTON_DOWN = 3'd0;
	localparam logic [2:0] CMD_BUTTON_UP   = 3'd1;
	localparam logic [2:0] CMD_LOCK        = 3'd2;
	localparam logic [2:0] CMD_UNLOCK      = 3'd3;
	localparam logic [2:0] CMD_MOVE        = 3'd4;
	localparam logic [2:0] CMD_TICK        = 3'd5;

	// reported gestures
	localparam logic [2:0] GEST_NONE       = 3'd0;
	localparam logic [2:0] GEST_CLICK      = 3'd1;
	localparam logic [2:0] GEST_DRAG_START = 3'd2;
	localparam logic [2:0] GEST_DRAG       = 3'd3;
	localparam logic [2:0] GEST_DRAG_END   = 3'd4;

	typedef struct packed {
		logic [2:0]           command;
		logic [CoordBits-1:0] pos_x;
		logic [CoordBits-1:0] pos_y;
		logic                 left_held;
	} evt_t;

	typedef struct packed {
		logic [2:0]           gesture;
		logic [CoordBits-1:0] out_x;
		logic [CoordBits-1:0] out_y;
		logic                 button_flag;
	} res_t;

	typedef struct packed {
		logic [ThreshBits-1:0] drag_threshold_sq;
		logic [TicksBits-1:0]  auto_drag_ticks;
	} cfg_t;

	typedef struct packed {
		logic [CoordBits-1:0] origin_x;
		logic [CoordBits-1:0] origin_y;
		logic                 pressed;
		logic                 dragging;
		logic                 locked;
		logic                 countdown_armed;
		logic [TicksBits-1:0] countdown;
	} state_t;

endpackage

`default_nettype wire

FILE: sv/cdg_cfg.sv
// ----------------------------------------------------------------------------
// cdg_cfg: configuration registers
// Drag threshold and auto-drag tick count, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module cdg_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [cdg_pkg::CfgIdxBits-1:0]  cfg_index,
	input  wire logic [cdg_pkg::CfgDataBits-1:0] cfg_data,
	output cdg_pkg::cfg_t                        cfg
);

	cdg_pkg::cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drag_threshold_sq <= cdg_pkg::THRESH_RESET;
			cfg_q.auto_drag_ticks   <= cdg_pkg::TICKS_RESET;
		end else if (cfg_we) begin
			if (cfg_index == cdg_pkg::REG_DRAG_THRESHOLD_SQ) begin
				cfg_q.drag_threshold_sq <= cfg_data[cdg_pkg::ThreshBits-1:0];
			end
			if (cfg_index == cdg_pkg::REG_AUTO_DRAG_TICKS) begin
				cfg_q.auto_drag_ticks <= cfg_data[cdg_pkg::TicksBits-1:0];
			end
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: sv/cdg_step.sv
// ----------------------------------------------------------------------------
// cdg_step: gesture decision logic
// From the current state, the registers and one request, forms the next state
// and the one result the request causes.
// ----------------------------------------------------------------------------
`default_nettype none

module cdg_step (
	input  wire cdg_pkg::state_t st,
	input  wire cdg_pkg::cfg_t   cfg,
	input  wire cdg_pkg::evt_t   evt,
	output cdg_pkg::state_t      st_nxt,
	output cdg_pkg::res_t        res
);

	logic [cdg_pkg::CoordBits-1:0]   adx;
	logic [cdg_pkg::CoordBits-1:0]   ady;
	logic [2*cdg_pkg::CoordBits-1:0] sq_x;
	logic [2*cdg_pkg::CoordBits-1:0] sq_y;
	logic [cdg_pkg::DistBits-1:0]    dist_sq;
	logic                            far;

	// squared distance from the stored origin
	always_comb begin
		adx  = (evt.pos_x >= st.origin_x) ? evt.pos_x - st.origin_x
			: st.origin_x - evt.pos_x;
		ady  = (evt.pos_y >= st.origin_y) ? evt.pos_y - st.origin_y
			: st.origin_y - evt.pos_y;
		sq_x = adx * adx;
		sq_y = ady * ady;
		dist_sq = cdg_pkg::DistBits'(sq_x) + cdg_pkg::DistBits'(sq_y);
		far  = dist_sq > cdg_pkg::DistBits'(cfg.drag_threshold_sq);
	end

	// per-command state update and result
	always_comb begin
		st_nxt          = st;
		res.gesture     = cdg_pkg::GEST_NONE;
		res.out_x       = '0;
		res.out_y       = '0;
		res.button_flag = 1'b0;
		case (evt.command)
			cdg_pkg::CMD_BUTTON_DOWN: begin
				st_nxt.origin_x        = evt.pos_x;
				st_nxt.origin_y        = evt.pos_y;
				st_nxt.dragging        = 1'b0;
				st_nxt.pressed         = 1'b1;
				st_nxt.countdown       = cfg.auto_drag_ticks;
				st_nxt.countdown_armed = 1'b1;
			end
			cdg_pkg::CMD_BUTTON_UP: begin
				st_nxt.countdown_armed = 1'b0;
				st_nxt.dragging        = 1'b0;
				st_nxt.pressed         = 1'b0;
				if (st.dragging) begin
					res.gesture = cdg_pkg::GEST_DRAG_END;
					res.out_x   = evt.pos_x;
					res.out_y   = evt.pos_y;
				end else if (st.pressed) begin
					res.gesture = cdg_pkg::GEST_CLICK;
					res.out_x   = st.origin_x;
					res.out_y   = st.origin_y;
				end
			end
			cdg_pkg::CMD_LOCK: begin
				st_nxt.locked = 1'b1;
			end
			cdg_pkg::CMD_UNLOCK: begin
				st_nxt.dragging = 1'b0;
				st_nxt.locked   = 1'b0;
				res.gesture     = cdg_pkg::GEST_DRAG_END;
				res.out_x       = evt.pos_x;
				res.out_y       = evt.pos_y;
			end
			cdg_pkg::CMD_MOVE: begin
				if (st.locked || evt.left_held) begin
					if (st.dragging) begin
						res.gesture     = cdg_pkg::GEST_DRAG;
						res.out_x       = evt.pos_x;
						res.out_y       = evt.pos_y;
						res.button_flag = 1'b1;
					end else if (st.locked) begin
						// locked: origin jumps to the pointer and the drag starts
						st_nxt.origin_x        = evt.pos_x;
						st_nxt.origin_y        = evt.pos_y;
						st_nxt.countdown_armed = 1'b0;
						st_nxt.dragging        = 1'b1;
						res.gesture            = cdg_pkg::GEST_DRAG_START;
						res.out_x              = evt.pos_x;
						res.out_y              = evt.pos_y;
						res.button_flag        = 1'b1;
					end else if (far) begin
						st_nxt.countdown_armed = 1'b0;
						st_nxt.dragging        = 1'b1;
						res.gesture            = cdg_pkg::GEST_DRAG_START;
						res.out_x              = st.origin_x;
						res.out_y              = st.origin_y;
						res.button_flag        = 1'b1;
					end
				end
			end
			cdg_pkg::CMD_TICK: begin
				if (st.countdown_armed) begin
					if (st.countdown <= cdg_pkg::TicksBits'(1)) begin
						// countdown expired
						st_nxt.countdown       = '0;
						st_nxt.countdown_armed = 1'b0;
						st_nxt.dragging        = st.pressed;
						if (st.pressed) begin
							res.gesture     = cdg_pkg::GEST_DRAG_START;
							res.out_x       = st.origin_x;
							res.out_y       = st.origin_y;
							res.button_flag = 1'b1;
						end
					end else begin
						st_nxt.countdown = st.countdown - cdg_pkg::TicksBits'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: sv/click_drag_gesture_recognizer_unit.sv
// ----------------------------------------------------------------------------
// click_drag_gesture_recognizer_unit: pointer click / drag detector
// Turns pointer requests (button, lock, move, tick) into click and drag
// gestures, one result per request.
// ----------------------------------------------------------------------------
//   channel  direction  handshake              payload
//   evt      in         evt_valid / evt_stall  cdg_pkg::evt_t
//   res      out        res_valid / res_stall  cdg_pkg::res_t
//   cfg      in         cfg_we                 cfg_index, cfg_data
//
// A request is registered, then decided combinationally into the result register;
// one request per cycle is sustained while the result is not stalled.
// The gesture state advances when a request moves into the result register.
// A stalled result holds; the input register still takes one more request.
// Reset clears state, valids and registers to their reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module click_drag_gesture_recognizer_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            evt_valid,
	output logic                                 evt_stall,
	input  wire cdg_pkg::evt_t                   evt,
	output logic                                 res_valid,
	input  wire logic                            res_stall,
	output cdg_pkg::res_t                        res,
	input  wire logic                            cfg_we,
	input  wire logic [cdg_pkg::CfgIdxBits-1:0]  cfg_index,
	input  wire logic [cdg_pkg::CfgDataBits-1:0] cfg_data
);

	cdg_pkg::cfg_t   cfg;
	cdg_pkg::state_t state_q;
	cdg_pkg::state_t state_nxt;
	cdg_pkg::evt_t   evt_s1;
	cdg_pkg::res_t   res_nxt;
	cdg_pkg::res_t   res_q;
	logic            valid_s1;
	logic            res_valid_q;
	logic            advance;
	logic            accept;

	cdg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cdg_step u_step (
		.st     (state_q),
		.cfg    (cfg),
		.evt    (evt_s1),
		.st_nxt (state_nxt),
		.res    (res_nxt)
	);

	// handshake
	assign advance   = valid_s1 && (!res_valid_q || !res_stall);
	assign evt_stall = valid_s1 && !advance;
	assign accept    = evt_valid && !evt_stall;

	// valids and gesture state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
				state_q     <= state_nxt;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			evt_s1 <= evt;
		end
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

FILE: sv/cdg_checker.sv
// ----------------------------------------------------------------------------
// cdg_checker: port checks for the gesture recognizer
// Watches the top level ports and flags inconsistent results or stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module cdg_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          evt_stall,
	input wire logic          res_valid,
	input wire logic          res_stall,
	input wire cdg_pkg::res_t res
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

	// input stalls only behind a stalled full result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		evt_stall |-> res_valid && res_stall)
		else $error("input stalled without output back-pressure");

	// button flag marks drag start and drag only
	a_button_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.button_flag == (res.gesture == cdg_pkg::GEST_DRAG_START ||
			res.gesture == cdg_pkg::GEST_DRAG))
		else $error("button flag disagrees with gesture");

	// an empty gesture carries zero coordinates
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.gesture == cdg_pkg::GEST_NONE |->
			res.out_x == '0 && res.out_y == '0)
		else $error("empty gesture with coordinates");

endmodule

bind click_drag_gesture_recognizer_unit cdg_checker u_cdg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.evt_stall (evt_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

`default_nettype wire

FILE: sim/gesture_checker.sv
// ----------------------------------------------------------------------------
// gesture_checker: result checker for the click / drag gesture recognizer
// Watches the request, result and register ports, keeps its own copy of the
// pointer state and registers, predicts one gesture per accepted request and
// compares every accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module gesture_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            evt_valid,
	input  wire logic                            evt_stall,
	input  wire cdg_pkg::evt_t                   evt,
	input  wire logic                            res_valid,
	input  wire logic                            res_stall,
	input  wire cdg_pkg::res_t                   res,
	input  wire logic                            cfg_we,
	input  wire logic [cdg_pkg::CfgIdxBits-1:0]  cfg_index,
	input  wire logic [cdg_pkg::CfgDataBits-1:0] cfg_data,
	input  wire logic                            wrap_up,
	output int                                   failures,
	output int                                   pending,
	output int                                   checked,
	output int                                   gestures_seen
);
	import cdg_pkg::*;

	state_t ptr_state;
	cfg_t   reg_file;
	res_t   expected_gestures[$];
	bit     wrapped;

	initial begin
		failures      = 0;
		pending       = 0;
		checked       = 0;
		gestures_seen = 0;
		wrapped       = 1'b0;
	end

	// one line per problem, printing capped so a broken block cannot flood the log
	task automatic report(input string msg);
		failures++;
		if (failures <= 100)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	// next gesture for one request; advances the tracked pointer state
	function automatic res_t recognize_gesture(input evt_t e);
		res_t                 r;
		logic [CoordBits-1:0] ax, ay;
		logic [DistBits:0]    dist_sq;
		r = '0;
		case (e.command)
			CMD_BUTTON_DOWN: begin
				ptr_state.origin_x        = e.pos_x;
				ptr_state.origin_y        = e.pos_y;
				ptr_state.dragging        = 1'b0;
				ptr_state.pressed         = 1'b1;
				ptr_state.countdown       = reg_file.auto_drag_ticks;
				ptr_state.countdown_armed = 1'b1;
			end
			CMD_BUTTON_UP: begin
				ptr_state.countdown_armed = 1'b0;
				if (ptr_state.dragging) begin
					r.gesture = GEST_DRAG_END;
					r.out_x   = e.pos_x;
					r.out_y   = e.pos_y;
				end else if (ptr_state.pressed) begin
					r.gesture = GEST_CLICK;
					r.out_x   = ptr_state.origin_x;
					r.out_y   = ptr_state.origin_y;
				end
				ptr_state.dragging = 1'b0;
				ptr_state.pressed  = 1'b0;
			end
			CMD_LOCK: begin
				ptr_state.locked = 1'b1;
			end
			CMD_UNLOCK: begin
				ptr_state.dragging = 1'b0;
				ptr_state.locked   = 1'b0;
				r.gesture = GEST_DRAG_END;
				r.out_x   = e.pos_x;
				r.out_y   = e.pos_y;
			end
			CMD_MOVE: begin
				if (ptr_state.locked || e.left_held) begin
					if (ptr_state.dragging) begin
						r.gesture     = GEST_DRAG;
						r.out_x       = e.pos_x;
						r.out_y       = e.pos_y;
						r.button_flag = 1'b1;
					end else begin
						// locked moves re-anchor the origin and start at once
						if (ptr_state.locked) begin
							ptr_state.origin_x = e.pos_x;
							ptr_state.origin_y = e.pos_y;
						end
						ax = (e.pos_x >= ptr_state.origin_x) ? e.pos_x - ptr_state.origin_x :
							ptr_state.origin_x - e.pos_x;
						ay = (e.pos_y >= ptr_state.origin_y) ? e.pos_y - ptr_state.origin_y :
							ptr_state.origin_y - e.pos_y;
						dist_sq = (DistBits+1)'(ax) * (DistBits+1)'(ax) +
							(DistBits+1)'(ay) * (DistBits+1)'(ay);
						if (ptr_state.locked ||
							dist_sq > (DistBits+1)'(reg_file.drag_threshold_sq)) begin
							ptr_state.countdown_armed = 1'b0;
							ptr_state.dragging        = 1'b1;
							r.gesture     = GEST_DRAG_START;
							r.out_x       = ptr_state.origin_x;
							r.out_y       = ptr_state.origin_y;
							r.button_flag = 1'b1;
						end
					end
				end
			end
			CMD_TICK: begin
				if (ptr_state.countdown_armed) begin
					if (ptr_state.countdown <= TicksBits'(1)) begin
						ptr_state.countdown       = '0;
						ptr_state.countdown_armed = 1'b0;
						if (ptr_state.pressed) begin
							ptr_state.dragging = 1'b1;
							r.gesture     = GEST_DRAG_START;
							r.out_x       = ptr_state.origin_x;
							r.out_y       = ptr_state.origin_y;
							r.button_flag = 1'b1;
						end else begin
							ptr_state.dragging = 1'b0;
						end
					end else begin
						ptr_state.countdown = ptr_state.countdown - TicksBits'(1);
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// register writes, result compare, request prediction
	always @(posedge clk) begin
		res_t want;
		if (!arst_n) begin
			ptr_state                  = '0;
			reg_file.drag_threshold_sq = THRESH_RESET;
			reg_file.auto_drag_ticks   = TICKS_RESET;
			expected_gestures.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DRAG_THRESHOLD_SQ: reg_file.drag_threshold_sq = cfg_data[ThreshBits-1:0];
					REG_AUTO_DRAG_TICKS:   reg_file.auto_drag_ticks   = cfg_data[TicksBits-1:0];
					default: begin
					end
				endcase
			end
			if (res_valid && !res_stall) begin
				if (expected_gestures.size() == 0) begin
					report($sformatf("unexpected result gesture %0d at (%0d,%0d)",
						res.gesture, res.out_x, res.out_y));
				end else begin
					want = expected_gestures.pop_front();
					if (res.gesture !== want.gesture)
						report($sformatf("result %0d gesture: expected %0d, got %0d",
							checked, want.gesture, res.gesture));
					if (res.out_x !== want.out_x)
						report($sformatf("result %0d out_x: expected %0d, got %0d",
							checked, want.out_x, res.out_x));
					if (res.out_y !== want.out_y)
						report($sformatf("result %0d out_y: expected %0d, got %0d",
							checked, want.out_y, res.out_y));
					if (res.button_flag !== want.button_flag)
						report($sformatf("result %0d button_flag: expected %0d, got %0d",
							checked, want.button_flag, res.button_flag));
					if (want.gesture != GEST_NONE)
						gestures_seen++;
					checked++;
				end
			end
			if (evt_valid && !evt_stall)
				expected_gestures.push_back(recognize_gesture(evt));
			// anything still waiting at the end never arrived
			if (wrap_up && !wrapped) begin
				wrapped = 1'b1;
				if (expected_gestures.size() != 0)
					report($sformatf("%0d expected results never arrived",
						expected_gestures.size()));
			end
		end
		pending = expected_gestures.size();
	end

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for click_drag_gesture_recognizer_unit
// Drives pointer requests (directed corner cases, then press, lock and noise
// sequences with random content) under several register settings, with random
// sender gaps and result stalls; the checker beside the block does the compare.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import cdg_pkg::*;

	localparam int CycleLimit = 1000000;
	localparam int CoordMax   = (1 << CoordBits) - 1;

	logic                   clk;
	logic                   arst_n;
	logic                   evt_valid;
	logic                   evt_stall;
	evt_t                   evt;
	logic                   res_valid;
	logic                   res_stall;
	res_t                   res;
	logic                   cfg_we;
	logic [CfgIdxBits-1:0]  cfg_index;
	logic [CfgDataBits-1:0] cfg_data;
	logic                   wrap_up;

	int failures, pending, checked, gestures_seen;
	int requests_sent, unknown_sent, settings_used, cycle_count;
	int gap_mode, stall_mode, stall_left, run_left;
	int cur_ticks, reach;

	click_drag_gesture_recognizer_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	gesture_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.evt_valid     (evt_valid),
		.evt_stall     (evt_stall),
		.evt           (evt),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.res           (res),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.wrap_up       (wrap_up),
		.failures      (failures),
		.pending       (pending),
		.checked       (checked),
		.gestures_seen (gestures_seen)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
			$display("FAIL click_drag_gesture_recognizer_unit");
			$finish;
		end
	end

	// result stalls: free runs between stall bursts, mostly short, a few long
	always @(negedge clk) begin
		int r;
		if (stall_left > 0) begin
			res_stall <= 1'b1;
			stall_left--;
		end else begin
			res_stall <= 1'b0;
			if (run_left > 0) begin
				run_left--;
			end else if (stall_mode != 0) begin
				run_left = (stall_mode == 1) ? $urandom_range(4, 30) : $urandom_range(0, 6);
				r = $urandom_range(0, 99);
				stall_left = (r < 80) ? $urandom_range(1, 3) :
					(r < 97) ? $urandom_range(4, 10) : $urandom_range(20, 60);
			end
		end
	end

	// one request through the handshake, after a random gap
	task automatic send_evt(input logic [2:0] cmd, input int x, input int y, input bit held);
		evt_t e;
		int   gap;
		int   r;
		gap = 0;
		if (gap_mode != 0) begin
			r = $urandom_range(0, 99);
			gap = (r < 55) ? 0 : (r < 85) ? $urandom_range(1, 3) :
				(r < 97) ? $urandom_range(4, 10) : $urandom_range(20, 60);
		end
		if (gap > 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		e.command   = cmd;
		e.pos_x     = x[CoordBits-1:0];
		e.pos_y     = y[CoordBits-1:0];
		e.left_held = held;
		evt       <= e;
		evt_valid <= 1'b1;
		do @(posedge clk); while (evt_stall);
		@(negedge clk);
		if (cmd > CMD_TICK)
			unknown_sent++;
		else
			requests_sent++;
	endtask

	// stop sending until every expected result is back
	task automatic wait_idle();
		evt_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// both registers, one write per cycle
	task automatic set_config(input logic [ThreshBits-1:0] thr, input logic [TicksBits-1:0] ticks);
		cfg_we    <= 1'b1;
		cfg_index <= REG_DRAG_THRESHOLD_SQ;
		cfg_data  <= CfgDataBits'(thr);
		@(negedge clk);
		cfg_index <= REG_AUTO_DRAG_TICKS;
		cfg_data  <= CfgDataBits'(ticks);
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_ticks = ticks;
		// smallest per-axis offset whose square alone passes the threshold
		reach = 1;
		while (reach <= CoordMax && longint'(reach) * reach <= longint'(thr)) reach++;
		settings_used++;
	endtask

	// coordinate, biased toward the edges
	function automatic int rand_coord();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0) return 0;
		if (r == 1) return CoordMax;
		return $urandom_range(0, CoordMax);
	endfunction

	// coordinate within span of base, clamped to the screen
	function automatic int near(input int base, input int span);
		int v;
		v = base + $urandom_range(0, 2 * span) - span;
		if (v < 0) v = 0;
		if (v > CoordMax) v = CoordMax;
		return v;
	endfunction

	// move offset: tiny, around the threshold, medium or anywhere
	function automatic int pick_span();
		case ($urandom_range(0, 3))
			0: return 2;
			1: return reach + 1;
			2: return 40;
			default: return CoordMax;
		endcase
	endfunction

	task automatic noise_request();
		send_evt(3'($urandom_range(0, 7)), rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
	endtask

	// button down, held moves and ticks, button up
	task automatic press_sequence();
		int ox, oy, cx, cy, steps, sel;
		ox = rand_coord();
		oy = rand_coord();
		cx = ox;
		cy = oy;
		send_evt(CMD_BUTTON_DOWN, ox, oy, 1'($urandom_range(0, 1)));
		steps = $urandom_range(0, 8);
		for (int k = 0; k < steps; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < 60) begin
				cx = near(ox, pick_span());
				cy = near(oy, pick_span());
				send_evt(CMD_MOVE, cx, cy, 1'b1);
			end else if (sel < 85) begin
				send_evt(CMD_TICK, rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
			end else if (sel < 95) begin
				send_evt(CMD_MOVE, near(cx, pick_span()), near(cy, pick_span()), 1'b0);
			end else begin
				noise_request();
			end
		end
		// up to enough ticks to run a short countdown out
		if (cur_ticks <= 16 && $urandom_range(0, 2) == 0)
			repeat ($urandom_range(0, cur_ticks + 1))
				send_evt(CMD_TICK, rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
		send_evt(CMD_BUTTON_UP, cx, cy, 1'($urandom_range(0, 1)));
	endtask

	// lock, moves with either button state, ticks and button events, unlock
	task automatic lock_sequence();
		int cx, cy, steps, sel;
		cx = rand_coord();
		cy = rand_coord();
		send_evt(CMD_LOCK, cx, cy, 1'($urandom_range(0, 1)));
		steps = $urandom_range(1, 6);
		for (int k = 0; k < steps; k++) begin
			sel = $urandom_range(0, 99);
			cx = near(cx, pick_span());
			cy = near(cy, pick_span());
			if (sel < 75)
				send_evt(CMD_MOVE, cx, cy, 1'($urandom_range(0, 1)));
			else if (sel < 85)
				send_evt(CMD_TICK, cx, cy, 1'($urandom_range(0, 1)));
			else if (sel < 93)
				send_evt(CMD_BUTTON_DOWN, cx, cy, 1'($urandom_range(0, 1)));
			else
				send_evt(CMD_BUTTON_UP, cx, cy, 1'($urandom_range(0, 1)));
		end
		send_evt(CMD_UNLOCK, rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
	endtask

	// one register setting with a batch of random sequences
	task automatic run_phase(input logic [ThreshBits-1:0] thr, input logic [TicksBits-1:0] ticks,
		input int count, input bit idling);
		int target, sel;
		wait_idle();
		set_config(thr, ticks);
		gap_mode   = idling;
		stall_mode = idling ? $urandom_range(1, 2) : 0;
		target = requests_sent + count;
		while (requests_sent < target) begin
			sel = $urandom_range(0, 99);
			if (sel < 55)
				press_sequence();
			else if (sel < 75)
				lock_sequence();
			else if (sel < 98)
				noise_request();
			else
				wait_idle();
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		evt_valid     = 1'b0;
		evt           = '0;
		res_stall     = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_DRAG_THRESHOLD_SQ;
		cfg_data      = '0;
		wrap_up       = 1'b0;
		requests_sent = 0;
		unknown_sent  = 0;
		settings_used = 0;
		gap_mode      = 0;
		stall_mode    = 0;
		stall_left    = 0;
		run_left      = 0;
		cur_ticks     = TICKS_RESET;
		reach         = 6;

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, reset register values: threshold 25, countdown 1000
		send_evt(CMD_MOVE, CoordMax, CoordMax, 1'b1);   // held move with no press
		send_evt(CMD_MOVE, 0, 0, 1'b1);
		send_evt(CMD_BUTTON_UP, CoordMax, 0, 1'b0);
		send_evt(CMD_BUTTON_UP, 1, 1, 1'b1);            // up with nothing pressed
		send_evt(CMD_BUTTON_DOWN, 100, 200, 1'b0);
		send_evt(CMD_MOVE, 103, 204, 1'b1);             // distance equals threshold
		send_evt(CMD_MOVE, 104, 204, 1'b1);             // just past it
		send_evt(CMD_BUTTON_UP, 200, 300, 1'b0);
		send_evt(CMD_BUTTON_DOWN, CoordMax, CoordMax, 1'b1);
		send_evt(CMD_MOVE, 0, 0, 1'b0);                 // released move is ignored
		send_evt(CMD_BUTTON_UP, 0, 0, 1'b0);            // click at origin
		send_evt(CMD_LOCK, 12, 34, 1'b0);
		send_evt(CMD_MOVE, 50, 60, 1'b0);               // locked move starts at once
		send_evt(CMD_MOVE, 0, CoordMax, 1'b1);
		send_evt(CMD_UNLOCK, 7, 9, 1'b1);
		send_evt(CMD_TICK, CoordMax, CoordMax, 1'b1);   // countdown not armed
		send_evt(3'd6, 1, 2, 1'b0);                     // unknown commands
		send_evt(3'd7, CoordMax, CoordMax, 1'b1);

		// zero threshold and zero countdown
		wait_idle();
		set_config('0, '0);
		send_evt(CMD_BUTTON_DOWN, 5, 5, 1'b0);
		send_evt(CMD_TICK, 0, 0, 1'b0);                 // expires on the first tick
		send_evt(CMD_BUTTON_DOWN, 6, 6, 1'b0);
		send_evt(CMD_MOVE, 6, 6, 1'b1);
		send_evt(CMD_MOVE, 7, 6, 1'b1);
		send_evt(CMD_BUTTON_UP, 7, 6, 1'b0);

		// largest threshold: even corner to corner stays below it
		wait_idle();
		set_config({ThreshBits{1'b1}}, TicksBits'(2));
		send_evt(CMD_BUTTON_DOWN, CoordMax, 0, 1'b0);
		send_evt(CMD_MOVE, 0, CoordMax, 1'b1);
		send_evt(CMD_TICK, 0, 0, 1'b0);
		send_evt(CMD_TICK, 0, 0, 1'b0);
		send_evt(CMD_BUTTON_UP, 0, CoordMax, 1'b0);

		// random sequences over a spread of settings
		run_phase(ThreshBits'(25), TicksBits'(1000), 200, 1'b0);
		run_phase('0, TicksBits'(1), 200, 1'b1);
		run_phase({ThreshBits{1'b1}}, {TicksBits{1'b1}}, 200, 1'b1);
		run_phase(ThreshBits'($urandom_range(0, 400)), TicksBits'($urandom_range(1, 6)), 200, 1'b1);
		run_phase(ThreshBits'($urandom), TicksBits'($urandom_range(2, 12)), 200, 1'b1);
		run_phase({ThreshBits{1'b1}}, TicksBits'(1), 200, 1'b1);
		run_phase(ThreshBits'($urandom_range(1, 100)), {TicksBits{1'b1}}, 200, 1'b1);
		run_phase(ThreshBits'($urandom_range(0, 50)), TicksBits'($urandom_range(1, 4)), 200, 1'b1);

		wait_idle();
		repeat (8) @(negedge clk);
		wrap_up <= 1'b1;
		repeat (2) @(negedge clk);

		$display("covered %0d requests and %0d unknown commands over %0d register settings",
			requests_sent, unknown_sent, settings_used);
		$display("checked %0d results, %0d of them click or drag gestures, in %0d cycles",
			checked, gestures_seen, cycle_count);
		if (failures == 0)
			$display("PASS click_drag_gesture_recognizer_unit");
		else
			$display("FAIL click_drag_gesture_recognizer_unit");
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
sv/cdg_pkg.sv
sv/cdg_cfg.sv
sv/cdg_step.sv
sv/click_drag_gesture_recognizer_unit.sv
sv/cdg_checker.sv
sim/gesture_checker.sv
sim/tb_top.sv
